### rtl/rts_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rts_pkg
// Shared types, constants and the sine table of the rotozoom texture sampler.
// ----------------------------------------------------------------------------
package rts_pkg;

   localparam int TEX_WIDTH     = 128;
   localparam int TEX_HEIGHT    = 128;
   localparam int SCREEN_WIDTH  = 320;

   localparam int TEX_U_BITS    = $clog2(TEX_WIDTH);
   localparam int TEX_V_BITS    = $clog2(TEX_HEIGHT);
   localparam int TEX_IDX_BITS  = 14;
   localparam int TEX_DEPTH     = 2 ** TEX_IDX_BITS;
   localparam int ADDR_BITS     = 17;

   localparam int ANGLE_BITS    = 9;
   localparam int SPEED_RESET   = 2;
   localparam int FULL_TURN     = 360;
   localparam int QUARTER_TURN  = 90;
   localparam int HALF_TURN     = 180;
   localparam int THREE_QUARTER = 270;

   // zoom of 6/5: |num| * 6 >> ZOOM_SHIFT, then divide by 5 by reciprocal
   localparam int ZOOM_SHIFT    = 28;
   localparam int QUOT_IN_BITS  = 13;
   localparam int RECIP         = 3277;
   localparam int RECIP_BITS    = 12;
   localparam int RECIP_SHIFT   = 14;
   localparam int QUOT_BITS     = 11;

   localparam logic [1:0] KIND_LOAD  = 2'd0;
   localparam logic [1:0] KIND_PIXEL = 2'd1;
   localparam logic [1:0] KIND_TICK  = 2'd2;

   typedef struct packed {
      logic [1:0]  kind;
      logic [13:0] texel_index;
      logic [15:0] texel_value;
      logic [8:0]  pixel_x;
      logic [7:0]  pixel_y;
   } req_payload_type;

   typedef struct packed {
      logic [16:0] pixel_address;
      logic [7:0]  color;
   } rsp_payload_type;

   typedef struct packed {
      logic               is_load;
      logic [13:0]        texel_index;
      logic [15:0]        texel_value;
      logic [8:0]         pixel_x;
      logic [7:0]         pixel_y;
      logic signed [15:0] sin_q14;
      logic signed [15:0] cos_q14;
   } work_type;

   localparam logic [14:0] QUARTER_SINE [91] = '{
      15'd0,     15'd286,   15'd572,   15'd857,   15'd1143,  15'd1428,  15'd1713,
      15'd1997,  15'd2280,  15'd2563,  15'd2845,  15'd3126,  15'd3406,  15'd3686,
      15'd3964,  15'd4240,  15'd4516,  15'd4790,  15'd5063,  15'd5334,  15'd5604,
      15'd5872,  15'd6138,  15'd6402,  15'd6664,  15'd6924,  15'd7182,  15'd7438,
      15'd7692,  15'd7943,  15'd8192,  15'd8438,  15'd8682,  15'd8923,  15'd9162,
      15'd9397,  15'd9630,  15'd9860,  15'd10087, 15'd10311, 15'd10531, 15'd10749,
      15'd10963, 15'd11174, 15'd11381, 15'd11585, 15'd11786, 15'd11982, 15'd12176,
      15'd12365, 15'd12551, 15'd12733, 15'd12911, 15'd13085, 15'd13255, 15'd13421,
      15'd13583, 15'd13741, 15'd13894, 15'd14044, 15'd14189, 15'd14330, 15'd14466,
      15'd14598, 15'd14726, 15'd14849, 15'd14968, 15'd15082, 15'd15191, 15'd15296,
      15'd15396, 15'd15491, 15'd15582, 15'd15668, 15'd15749, 15'd15826, 15'd15897,
      15'd15964, 15'd16026, 15'd16083, 15'd16135, 15'd16182, 15'd16225, 15'd16262,
      15'd16294, 15'd16322, 15'd16344, 15'd16362, 15'd16374, 15'd16382, 15'd16384
   };

   // angle is always below a full turn
   function automatic logic signed [15:0] sine_q14(input logic [ANGLE_BITS-1:0] a);
      logic [ANGLE_BITS-1:0] diff;
      logic [14:0]           mag;
      logic                  neg;
      if (a <= ANGLE_BITS'(QUARTER_TURN)) begin
         diff = a;
         neg  = 1'b0;
      end else if (a <= ANGLE_BITS'(HALF_TURN)) begin
         diff = ANGLE_BITS'(HALF_TURN) - a;
         neg  = 1'b0;
      end else if (a <= ANGLE_BITS'(THREE_QUARTER)) begin
         diff = a - ANGLE_BITS'(HALF_TURN);
         neg  = 1'b1;
      end else begin
         diff = ANGLE_BITS'(FULL_TURN) - a;
         neg  = 1'b1;
      end
      mag = QUARTER_SINE[diff[6:0]];
      return neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
   endfunction

endpackage

### rtl/rts_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rts_front
// Request decoder: holds speed and angle, tags pixels with sin and cos,
// forwards load and pixel requests to the work queue.
// ----------------------------------------------------------------------------
module rts_front (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_wr_en,
   input  logic [8:0]               csr_wr_data,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  rts_pkg::req_payload_type req_payload,
   output logic                     work_valid,
   input  logic                     work_ready,
   output rts_pkg::work_type        work
);

   logic [rts_pkg::ANGLE_BITS-1:0] speed_ff, speed_in;
   logic [rts_pkg::ANGLE_BITS-1:0] angle_ff, angle_in;
   logic [rts_pkg::ANGLE_BITS:0]   sum;
   logic [rts_pkg::ANGLE_BITS:0]   cos_angle;
   logic                           accept;
   logic                           forward;

   assign req_ready = work_ready;
   assign accept    = req_valid && req_ready;

   always_comb begin
      forward = 1'b0;
      unique case (req_payload.kind)
         rts_pkg::KIND_LOAD:  forward = 1'b1;
         rts_pkg::KIND_PIXEL: forward = 1'b1;
         default:             forward = 1'b0;
      endcase
   end

   assign work_valid = req_valid && forward;

   // next angle, sum at most 359 + 511 = 870
   always_comb begin
      sum = {1'b0, angle_ff} + {1'b0, speed_ff};
      if (sum >= (rts_pkg::ANGLE_BITS+1)'(2 * rts_pkg::FULL_TURN)) begin
         sum = sum - (rts_pkg::ANGLE_BITS+1)'(2 * rts_pkg::FULL_TURN);
      end else if (sum >= (rts_pkg::ANGLE_BITS+1)'(rts_pkg::FULL_TURN)) begin
         sum = sum - (rts_pkg::ANGLE_BITS+1)'(rts_pkg::FULL_TURN);
      end
      angle_in = angle_ff;
      if (accept && req_payload.kind == rts_pkg::KIND_TICK) begin
         angle_in = sum[rts_pkg::ANGLE_BITS-1:0];
      end
      speed_in = csr_wr_en ? csr_wr_data : speed_ff;
   end

   always_comb begin
      cos_angle = {1'b0, angle_ff} + (rts_pkg::ANGLE_BITS+1)'(rts_pkg::QUARTER_TURN);
      if (cos_angle >= (rts_pkg::ANGLE_BITS+1)'(rts_pkg::FULL_TURN)) begin
         cos_angle = cos_angle - (rts_pkg::ANGLE_BITS+1)'(rts_pkg::FULL_TURN);
      end
   end

   always_comb begin
      work.is_load     = (req_payload.kind == rts_pkg::KIND_LOAD);
      work.texel_index = req_payload.texel_index;
      work.texel_value = req_payload.texel_value;
      work.pixel_x     = req_payload.pixel_x;
      work.pixel_y     = req_payload.pixel_y;
      work.sin_q14     = rts_pkg::sine_q14(angle_ff);
      work.cos_q14     = rts_pkg::sine_q14(cos_angle[rts_pkg::ANGLE_BITS-1:0]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         speed_ff <= rts_pkg::ANGLE_BITS'(rts_pkg::SPEED_RESET);
         angle_ff <= '0;
      end else begin
         speed_ff <= speed_in;
         angle_ff <= angle_in;
      end
   end

endmodule

### rtl/rts_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rts_queue
// Four-entry work queue between the request decoder and the sampling pipe.
// ----------------------------------------------------------------------------
module rts_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   output logic              push_ready,
   input  rts_pkg::work_type push_data,
   output logic              pop_valid,
   input  logic              pop_ready,
   output rts_pkg::work_type pop_data
);

   localparam int DEPTH    = 4;
   localparam int PTR_BITS = $clog2(DEPTH);

   rts_pkg::work_type     slots_ff [DEPTH];
   logic [PTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [PTR_BITS:0]     count_ff, count_in;
   logic                  do_push;
   logic                  do_pop;

   assign push_ready = (count_ff != (PTR_BITS+1)'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = slots_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

### rtl/rts_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rts_back
// Sampling pipe: affine transform, 6/5 zoom with truncation, wrap into the
// texture, texture store access and RGB332 conversion.
// ----------------------------------------------------------------------------
module rts_back (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     work_valid,
   output logic                     work_ready,
   input  rts_pkg::work_type        work,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output rts_pkg::rsp_payload_type rsp_payload
);

   typedef struct packed {
      logic        is_load;
      logic [13:0] texel_index;
      logic [15:0] texel_value;
      logic [16:0] pixel_address;
   } tag_type;

   localparam int MAG_BITS  = 43;
   localparam int PROD_BITS = MAG_BITS + 3;

   logic [15:0] texture [rts_pkg::TEX_DEPTH];

   logic advance;
   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, out_valid_ff;
   tag_type tag_in, tag1_ff, tag2_ff, tag3_ff, tag4_ff;

   // stage 1
   logic signed [9:0]  x_s;
   logic signed [8:0]  y_s;
   logic signed [25:0] xc_in, ys_in, xs_in, yc_in;
   logic signed [25:0] xc_ff, ys_ff, xs_ff, yc_ff;
   logic signed [15:0] sin1_ff, sin2_ff;
   // stage 2
   logic signed [26:0] a_in, b_in, a_ff, b_ff;
   // stage 3
   logic signed [MAG_BITS-1:0] ma_in, mb_in, ma_ff, mb_ff;
   // stage 4
   logic [MAG_BITS-1:0]  mag_u, mag_v;
   logic [PROD_BITS-1:0] six_u, six_v;
   logic [rts_pkg::QUOT_IN_BITS-1:0] t_u_ff, t_v_ff;
   logic neg_v_ff;
   // stage 5
   logic [rts_pkg::QUOT_IN_BITS+rts_pkg::RECIP_BITS-1:0] pu, pv;
   logic [rts_pkg::QUOT_BITS-1:0]   q_u, q_v;
   logic [rts_pkg::TEX_U_BITS-1:0]  u;
   logic [rts_pkg::TEX_V_BITS-1:0]  v_rem, v;
   logic [rts_pkg::TEX_IDX_BITS-1:0] idx_in, idx5_ff;
   logic [15:0] val5_ff;
   logic [16:0] addr5_ff;
   logic        load5_ff;
   // output
   logic [15:0] texel_ff;
   logic [16:0] addr_out_ff;

   assign advance    = !out_valid_ff || rsp_ready;
   assign work_ready = advance;

   always_comb begin
      tag_in.is_load       = work.is_load;
      tag_in.texel_index   = work.texel_index;
      tag_in.texel_value   = work.texel_value;
      tag_in.pixel_address = 17'(32'(work.pixel_y) * rts_pkg::SCREEN_WIDTH
                                + 32'(work.pixel_x));
      x_s   = $signed({1'b0, work.pixel_x});
      y_s   = $signed({1'b0, work.pixel_y});
      xc_in = x_s * work.cos_q14;
      ys_in = y_s * work.sin_q14;
      xs_in = x_s * work.sin_q14;
      yc_in = y_s * work.cos_q14;
   end

   assign a_in  = xc_ff - ys_ff;
   assign b_in  = xs_ff + yc_ff;
   assign ma_in = a_ff * sin2_ff;
   assign mb_in = b_ff * sin2_ff;

   always_comb begin
      mag_u = ma_ff[MAG_BITS-1] ? $unsigned(-ma_ff) : $unsigned(ma_ff);
      mag_v = mb_ff[MAG_BITS-1] ? $unsigned(-mb_ff) : $unsigned(mb_ff);
      six_u = (PROD_BITS'(mag_u) << 2) + (PROD_BITS'(mag_u) << 1);
      six_v = (PROD_BITS'(mag_v) << 2) + (PROD_BITS'(mag_v) << 1);
   end

   // divide by 5 with a reciprocal, exact for the quotient range here
   always_comb begin
      pu    = t_u_ff * rts_pkg::RECIP_BITS'(rts_pkg::RECIP);
      pv    = t_v_ff * rts_pkg::RECIP_BITS'(rts_pkg::RECIP);
      q_u   = pu[rts_pkg::RECIP_SHIFT +: rts_pkg::QUOT_BITS];
      q_v   = pv[rts_pkg::RECIP_SHIFT +: rts_pkg::QUOT_BITS];
      u     = q_u[rts_pkg::TEX_U_BITS-1:0];
      v_rem = q_v[rts_pkg::TEX_V_BITS-1:0];
      v     = v_rem;
      if (neg_v_ff && v_rem != '0) begin
         v = rts_pkg::TEX_V_BITS'(rts_pkg::TEX_HEIGHT - 32'(v_rem));
      end
      idx_in = rts_pkg::TEX_IDX_BITS'(32'(v) * rts_pkg::TEX_WIDTH + 32'(u));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         v4_ff        <= 1'b0;
         v5_ff        <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         v1_ff        <= work_valid;
         v2_ff        <= v1_ff;
         v3_ff        <= v2_ff;
         v4_ff        <= v3_ff;
         v5_ff        <= v4_ff;
         out_valid_ff <= v5_ff && !load5_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         tag1_ff  <= tag_in;
         xc_ff    <= xc_in;
         ys_ff    <= ys_in;
         xs_ff    <= xs_in;
         yc_ff    <= yc_in;
         sin1_ff  <= work.sin_q14;

         tag2_ff  <= tag1_ff;
         a_ff     <= a_in;
         b_ff     <= b_in;
         sin2_ff  <= sin1_ff;

         tag3_ff  <= tag2_ff;
         ma_ff    <= ma_in;
         mb_ff    <= mb_in;

         tag4_ff  <= tag3_ff;
         t_u_ff   <= six_u[rts_pkg::ZOOM_SHIFT +: rts_pkg::QUOT_IN_BITS];
         t_v_ff   <= six_v[rts_pkg::ZOOM_SHIFT +: rts_pkg::QUOT_IN_BITS];
         neg_v_ff <= mb_ff[MAG_BITS-1];

         load5_ff <= tag4_ff.is_load;
         idx5_ff  <= tag4_ff.is_load ? tag4_ff.texel_index : idx_in;
         val5_ff  <= tag4_ff.texel_value;
         addr5_ff <= tag4_ff.pixel_address;
      end
   end

   // texture store: loads and reads pass the same stage in order
   always_ff @(posedge clock) begin
      if (advance && v5_ff) begin
         if (load5_ff) begin
            texture[idx5_ff] <= val5_ff;
         end else begin
            texel_ff    <= texture[idx5_ff];
            addr_out_ff <= addr5_ff;
         end
      end
   end

   assign rsp_valid                 = out_valid_ff;
   assign rsp_payload.pixel_address = addr_out_ff;
   assign rsp_payload.color         = {texel_ff[15:13], texel_ff[10:8], texel_ff[4:3]};

endmodule

### rtl/rotozoom_texture_sampler.sv
`timescale 1ns / 1ps
// a pixel request passes the work queue, pipe stages and output register
// throughput: one request per cycle while rsp_ready is high, set by the
// single-port texture store access stage in the sampling pipe
// reset: angle 0, speed 2, queue and pipe empty; texture store is not cleared
// ----------------------------------------------------------------------------
// rotozoom_texture_sampler
// Rotate-and-zoom texture sampler: decoder, work queue and sampling pipe.
// ----------------------------------------------------------------------------
module rotozoom_texture_sampler (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_wr_en,
   input  logic [8:0]               csr_wr_data,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  rts_pkg::req_payload_type req_payload,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output rts_pkg::rsp_payload_type rsp_payload
);

   logic              front_valid, front_ready;
   rts_pkg::work_type front_work;
   logic              back_valid, back_ready;
   rts_pkg::work_type back_work;

   rts_front u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .work_valid  (front_valid),
      .work_ready  (front_ready),
      .work        (front_work)
   );

   rts_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (front_valid),
      .push_ready (front_ready),
      .push_data  (front_work),
      .pop_valid  (back_valid),
      .pop_ready  (back_ready),
      .pop_data   (back_work)
   );

   rts_back u_back (
      .clock       (clock),
      .reset       (reset),
      .work_valid  (back_valid),
      .work_ready  (back_ready),
      .work        (back_work),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule

### verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the rotozoom texture sampler. A table of directed
// requests covers the reset angle, color channel extremes, screen corners,
// the unused kind and store index extremes. It is followed by random phases
// with different speed settings and idle patterns, including one long
// response hold-off. A behavioral model predicts the untyped pixels, typed
// rows carry theirs; a monitor compares each response with the oldest one.
// ----------------------------------------------------------------------------
module testbench;

   localparam int          LATENCY        = 6;
   localparam int          CYCLE_LIMIT    = 200000;
   localparam int          PHASE_REQUESTS = 115;
   localparam int          HOLD_CYCLES    = 300;
   localparam logic [1:0]  KIND_UNUSED    = 2'd3;

   localparam int QUARTER_WAVE [91] = '{
      0, 286, 572, 857, 1143, 1428, 1713, 1997, 2280, 2563,
      2845, 3126, 3406, 3686, 3964, 4240, 4516, 4790, 5063, 5334,
      5604, 5872, 6138, 6402, 6664, 6924, 7182, 7438, 7692, 7943,
      8192, 8438, 8682, 8923, 9162, 9397, 9630, 9860, 10087, 10311,
      10531, 10749, 10963, 11174, 11381, 11585, 11786, 11982, 12176, 12365,
      12551, 12733, 12911, 13085, 13255, 13421, 13583, 13741, 13894, 14044,
      14189, 14330, 14466, 14598, 14726, 14849, 14968, 15082, 15191, 15296,
      15396, 15491, 15582, 15668, 15749, 15826, 15897, 15964, 16026, 16083,
      16135, 16182, 16225, 16262, 16294, 16322, 16344, 16362, 16374, 16382,
      16384
   };

   typedef struct packed {
      logic [1:0]  kind;
      logic [13:0] texel_index;
      logic [15:0] texel_value;
      logic [8:0]  pixel_x;
      logic [7:0]  pixel_y;
      logic        typed;
      logic [16:0] pixel_address;
      logic [7:0]  color;
   } stimulus_row_type;

   localparam int DIRECTED_ROWS = 22;
   localparam stimulus_row_type DIRECTED [DIRECTED_ROWS] = '{
      '{rts_pkg::KIND_LOAD,  14'h0000, 16'hFFFF, 9'd0,   8'd0,   1'b0, 17'd0,     8'h00},
      '{rts_pkg::KIND_PIXEL, 14'h0000, 16'h0000, 9'd0,   8'd0,   1'b1, 17'd0,     8'hFF},
      '{rts_pkg::KIND_PIXEL, 14'h0000, 16'h0000, 9'd319, 8'd239, 1'b1, 17'd76799, 8'hFF},
      '{rts_pkg::KIND_PIXEL, 14'h0000, 16'h0000, 9'd511, 8'd255, 1'b1, 17'd82111, 8'hFF},
      '{rts_pkg::KIND_LOAD,  14'h0000, 16'h0000, 9'd0,   8'd0,   1'b0, 17'd0,     8'h00},
      '{rts_pkg::KIND_PIXEL, 14'h0000, 16'h0000, 9'd1,   8'd1,   1'b1, 17'd321,   8'h00},
      '{rts_pkg::KIND_LOAD,  14'h0000, 16'hF800, 9'd0,   8'd0,   1'b0, 17'd0,     8'h00},
      '{rts_pkg::KIND_PIXEL, 14'h0000, 16'h0000, 9'd0,   8'd1,   1'b1, 17'd320,   8'hE0},
      '{rts_pkg::KIND_LOAD,  14'h0000, 16'h07E0, 9'd0,   8'd0,   1'b0, 17'd0,     8'h00},
      '{rts_pkg::KIND_PIXEL, 14'h0000, 16'h0000, 9'd1,   8'd0,   1'b1, 17'd1,     8'h1C},
      '{rts_pkg::KIND_LOAD,  14'h0000, 16'h001F, 9'd0,   8'd0,   1'b0, 17'd0,     8'h00},
      '{rts_pkg::KIND_PIXEL, 14'h0000, 16'h0000, 9'd2,   8'd0,   1'b1, 17'd2,     8'h03},
      '{KIND_UNUSED,         14'h3FFF, 16'hFFFF, 9'd511, 8'd255, 1'b0, 17'd0,     8'h00},
      '{rts_pkg::KIND_LOAD,  14'h3FFF, 16'hFFFF, 9'd0,   8'd0,   1'b0, 17'd0,     8'h00},
      '{rts_pkg::KIND_LOAD,  14'h2AAA, 16'hAAAA, 9'd0,   8'd0,   1'b0, 17'd0,     8'h00},
      '{rts_pkg::KIND_LOAD,  14'h1555, 16'h5555, 9'd0,   8'd0,   1'b0, 17'd0,     8'h00},
      '{rts_pkg::KIND_TICK,  14'h0000, 16'h0000, 9'd0,   8'd0,   1'b0, 17'd0,     8'h00},
      '{rts_pkg::KIND_PIXEL, 14'h0000, 16'h0000, 9'd319, 8'd239, 1'b0, 17'd0,     8'h00},
      '{rts_pkg::KIND_PIXEL, 14'h0000, 16'h0000, 9'd511, 8'd255, 1'b0, 17'd0,     8'h00},
      '{rts_pkg::KIND_PIXEL, 14'h0000, 16'h0000, 9'd0,   8'd0,   1'b0, 17'd0,     8'h00},
      '{rts_pkg::KIND_TICK,  14'h0000, 16'h0000, 9'd0,   8'd0,   1'b0, 17'd0,     8'h00},
      '{rts_pkg::KIND_PIXEL, 14'h0000, 16'h0000, 9'd160, 8'd120, 1'b0, 17'd0,     8'h00}
   };

   localparam int PHASES = 5;
   localparam int PHASE_SPEED [PHASES] = '{359, 511, 0, 90, 1};
   localparam int PHASE_IDLE  [PHASES] = '{0, 67, 0, 26, 0};
   localparam int PHASE_STALL [PHASES] = '{0, 0, 67, 26, 0};

   logic                     clock;
   logic                     reset;
   logic                     csr_wr_en;
   logic [8:0]               csr_wr_data;
   logic                     req_valid;
   logic                     req_ready;
   rts_pkg::req_payload_type req_payload;
   logic                     rsp_valid;
   logic                     rsp_ready;
   rts_pkg::rsp_payload_type rsp_payload;

   rts_pkg::rsp_payload_type expected_pixels [$];
   logic [15:0]              texel_store [rts_pkg::TEX_DEPTH];
   bit                       texel_written [rts_pkg::TEX_DEPTH];
   int                       model_angle;
   int                       model_speed;
   int                       error_count;
   int unsigned              cycle_count;
   int                       sender_idle_pct;
   int                       receiver_stall_pct;
   int                       hold_left;
   int                       offered_count;

   rotozoom_texture_sampler u_dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   function automatic longint angle_sine(input int angle);
      int a;
      a = angle % 360;
      if (a <= 90) return QUARTER_WAVE[a];
      if (a <= 180) return QUARTER_WAVE[180 - a];
      if (a <= 270) return -QUARTER_WAVE[a - 180];
      return -QUARTER_WAVE[360 - a];
   endfunction

   // texture location sampled for screen pixel (x, y) at a given angle
   function automatic logic [13:0] sampled_texel(input int angle, input longint x,
                                                 input longint y);
      longint s;
      longint c;
      longint u;
      longint v;
      s = angle_sine(angle);
      c = angle_sine(angle + 90);
      u = (((x * c - y * s) * s * 6) / (longint'(5) << 28)) % rts_pkg::TEX_WIDTH;
      v = (((x * s + y * c) * s * 6) / (longint'(5) << 28)) % rts_pkg::TEX_HEIGHT;
      if (u < 0) u = -u;
      if (v < 0) v = v + rts_pkg::TEX_HEIGHT;
      return 14'(v * rts_pkg::TEX_WIDTH + u);
   endfunction

   function automatic logic [7:0] texel_color(input logic [15:0] texel);
      return {texel[15:13], texel[10:8], texel[4:3]};
   endfunction

   function automatic rts_pkg::req_payload_type random_payload(input logic [1:0] kind);
      rts_pkg::req_payload_type p;
      p.kind        = kind;
      p.texel_index = 14'($urandom);
      p.texel_value = 16'($urandom);
      p.pixel_x     = 9'($urandom);
      p.pixel_y     = 8'($urandom);
      return p;
   endfunction

   // advance the model on an accepted request and queue the pixel it produces
   function automatic void track_request(input rts_pkg::req_payload_type item,
                                         input logic typed,
                                         input rts_pkg::rsp_payload_type typed_pixel);
      rts_pkg::rsp_payload_type pixel;
      case (item.kind)
         rts_pkg::KIND_LOAD: begin
            texel_store[item.texel_index]   = item.texel_value;
            texel_written[item.texel_index] = 1'b1;
         end
         rts_pkg::KIND_TICK: begin
            model_angle = (model_angle + model_speed) % rts_pkg::FULL_TURN;
         end
         rts_pkg::KIND_PIXEL: begin
            pixel.pixel_address = 17'(int'(item.pixel_y) * rts_pkg::SCREEN_WIDTH
                                      + int'(item.pixel_x));
            pixel.color = texel_color(
               texel_store[sampled_texel(model_angle, item.pixel_x, item.pixel_y)]);
            expected_pixels.push_back(typed ? typed_pixel : pixel);
         end
         default: begin
         end
      endcase
   endfunction

   task automatic offer_request(input rts_pkg::req_payload_type item, input logic typed,
                                input rts_pkg::rsp_payload_type typed_pixel);
      int gap;
      req_payload <= item;
      req_valid   <= 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      track_request(item, typed, typed_pixel);
      offered_count++;
      gap = 0;
      while (gap < 20 && $urandom_range(99) < sender_idle_pct) gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // loads the sampled texel first when it has never been written
   task automatic render_pixel(input logic [8:0] x, input logic [7:0] y);
      rts_pkg::req_payload_type p;
      logic [13:0]              target;
      target = sampled_texel(model_angle, x, y);
      if (!texel_written[target]) begin
         p = random_payload(rts_pkg::KIND_LOAD);
         p.texel_index = target;
         offer_request(p, 1'b0, '0);
      end
      p = random_payload(rts_pkg::KIND_PIXEL);
      p.pixel_x = x;
      p.pixel_y = y;
      offer_request(p, 1'b0, '0);
   endtask

   task automatic drain_pipe();
      req_valid <= 1'b0;
      while (expected_pixels.size() != 0) @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   task automatic write_speed(input int speed);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= 9'(speed);
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      model_speed = speed;
   endtask

   task automatic random_requests(input int count, input logic with_hold);
      int          first;
      int          pick;
      logic [8:0]  x;
      logic [7:0]  y;
      first = offered_count;
      while (offered_count - first < count) begin
         pick = $urandom_range(99);
         if (pick < 3) begin
            offer_request(random_payload(KIND_UNUSED), 1'b0, '0);
         end else if (pick < 13) begin
            offer_request(random_payload(rts_pkg::KIND_TICK), 1'b0, '0);
         end else if (pick < 28) begin
            offer_request(random_payload(rts_pkg::KIND_LOAD), 1'b0, '0);
         end else begin
            x = ($urandom_range(3) == 0) ? 9'($urandom_range(511)) : 9'($urandom_range(319));
            y = ($urandom_range(3) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(239));
            render_pixel(x, y);
         end
         if (with_hold && offered_count - first >= count / 2) begin
            hold_left = HOLD_CYCLES;
            with_hold = 1'b0;
         end
      end
   endtask

   // response side: random stalls plus a single long hold-off
   initial begin
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_left > 0) begin
            rsp_ready <= 1'b0;
            hold_left--;
         end else begin
            rsp_ready <= ($urandom_range(99) >= receiver_stall_pct);
         end
      end
   end

   always @(posedge clock) begin : check_pixels
      rts_pkg::rsp_payload_type oldest;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_pixels.size() == 0) begin
            $error("unexpected pixel: pixel_address %0d color %h",
                   rsp_payload.pixel_address, rsp_payload.color);
            error_count++;
         end else begin
            oldest = expected_pixels.pop_front();
            if (rsp_payload.pixel_address !== oldest.pixel_address) begin
               $error("pixel_address expected %0d actual %0d",
                      oldest.pixel_address, rsp_payload.pixel_address);
               error_count++;
            end
            if (rsp_payload.color !== oldest.color) begin
               $error("color expected %h actual %h", oldest.color, rsp_payload.color);
               error_count++;
            end
         end
      end
   end

   initial begin
      stimulus_row_type         row;
      rts_pkg::req_payload_type item;
      error_count        = 0;
      cycle_count        = 0;
      hold_left          = 0;
      offered_count      = 0;
      sender_idle_pct    = 0;
      receiver_stall_pct = 0;
      model_angle        = 0;
      model_speed        = rts_pkg::SPEED_RESET;
      reset       <= 1'b1;
      req_valid   <= 1'b0;
      req_payload <= '0;
      csr_wr_en   <= 1'b0;
      csr_wr_data <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < DIRECTED_ROWS; i++) begin
         row = DIRECTED[i];
         if (row.kind == rts_pkg::KIND_PIXEL && !row.typed) begin
            render_pixel(row.pixel_x, row.pixel_y);
         end else begin
            item.kind        = row.kind;
            item.texel_index = row.texel_index;
            item.texel_value = row.texel_value;
            item.pixel_x     = row.pixel_x;
            item.pixel_y     = row.pixel_y;
            offer_request(item, row.typed, {row.pixel_address, row.color});
         end
      end

      for (int phase = 0; phase < PHASES; phase++) begin
         drain_pipe();
         write_speed(PHASE_SPEED[phase]);
         sender_idle_pct    = PHASE_IDLE[phase];
         receiver_stall_pct = PHASE_STALL[phase];
         random_requests(PHASE_REQUESTS, phase == 0);
      end

      drain_pipe();
      if (error_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

### rotozoom_texture_sampler.f
rtl/rts_pkg.sv
rtl/rts_front.sv
rtl/rts_queue.sv
rtl/rts_back.sv
rtl/rotozoom_texture_sampler.sv
verif/testbench.sv
